// ===== sv/i2a_pkg.sv =====
// Shared types and constants for the integer to ASCII formatter.
package i2a_pkg;

   // Beat layouts on the stream ports
   localparam int REQ_TDATA_W = 56;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 8;
   localparam int RSP_TUSER_W = 1;

   // Width of width and precision counts (both saturate well below 128)
   localparam int CNT_W = 7;

   // Conversion codes
   localparam logic [2:0] CMD_SDEC = 3'd0;
   localparam logic [2:0] CMD_UDEC = 3'd1;
   localparam logic [2:0] CMD_OCT  = 3'd2;
   localparam logic [2:0] CMD_HEXL = 3'd3;
   localparam logic [2:0] CMD_HEXU = 3'd4;
   localparam logic [2:0] CMD_BIN  = 3'd5;

   // ASCII characters
   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;

   typedef enum logic [1:0] {
      RADIX_DEC,
      RADIX_OCT,
      RADIX_HEX,
      RADIX_BIN
   } radix_type;

   // Classified job handed from the front end to the back end
   typedef struct packed {
      logic             valid_cmd;
      logic             has_sign;
      logic [7:0]       sign_char;
      radix_type        radix;
      logic             upper;
      logic             sep8;
      logic             left;
      logic [CNT_W-1:0] min_width;
      logic [CNT_W-1:0] target;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BCD,
      ST_GEN,
      ST_PREP,
      ST_EMIT
   } back_state_type;

endpackage

// ===== sv/i2a_front.sv =====
// Front end: accepts request beats, applies the flag rules and classifies the job.
module i2a_front import i2a_pkg::*; #(
   parameter int WORD_BITS         = 32,
   parameter int DIGIT_STORE_CHARS = 40,
   parameter int MAX_WIDTH         = 64
) (
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // value[31:0], alt_form, zero_pad, space_sign, left_align, plus_sign,
   // min_width[6:0], has_precision, precision[5:0], zero fill
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // cmd[2:0]
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   input  logic                   queue_full,
   output logic                   job_push,
   output job_type                job,
   output logic [WORD_BITS-1:0]   job_value
);

   logic [2:0]              cmd;
   logic [31:0]             value;
   logic                    alt_form;
   logic                    zero_pad;
   logic                    space_sign;
   logic                    left_align;
   logic                    plus_sign;
   logic [CNT_W-1:0]        min_width;
   logic                    has_precision;
   logic [5:0]              precision;
   logic [WORD_BITS+31:0]   value_ext;
   logic [WORD_BITS-1:0]    word;
   logic                    is_dec;
   logic                    negative;
   logic                    has_sign;
   logic                    zero_eff;
   logic [CNT_W-1:0]        minw_sat;
   logic [CNT_W-1:0]        prec_sat;
   logic [CNT_W-1:0]        target;

   // Unpack the beat
   assign cmd           = req_tuser[2:0];
   assign value         = req_tdata[31:0];
   assign alt_form      = req_tdata[32];
   assign zero_pad      = req_tdata[33];
   assign space_sign    = req_tdata[34];
   assign left_align    = req_tdata[35];
   assign plus_sign     = req_tdata[36];
   assign min_width     = req_tdata[43:37];
   assign has_precision = req_tdata[44];
   assign precision     = req_tdata[50:45];

   // Hold off while the queue is full
   assign req_tready = ~queue_full;
   assign job_push   = req_tvalid & ~queue_full;

   // Trim or widen the number to the word size
   assign value_ext = {{WORD_BITS{1'b0}}, value};
   assign word      = value_ext[WORD_BITS-1:0];

   assign is_dec   = (cmd == CMD_SDEC) || (cmd == CMD_UDEC);
   assign negative = (cmd == CMD_SDEC) && word[WORD_BITS-1];
   assign has_sign = is_dec & (negative | plus_sign | space_sign);
   assign zero_eff = zero_pad & ~left_align & ~has_precision;

   // Saturate width and precision
   assign minw_sat = (min_width > CNT_W'(MAX_WIDTH)) ? CNT_W'(MAX_WIDTH) : min_width;
   assign prec_sat = ({1'b0, precision} > CNT_W'(DIGIT_STORE_CHARS)) ?
                     CNT_W'(DIGIT_STORE_CHARS) : {1'b0, precision};

   // Work out the minimum digit count
   always_comb begin
      target = has_precision ? prec_sat : CNT_W'(1);
      if (zero_eff) begin
         target = minw_sat;
         if (has_sign && target > CNT_W'(1)) begin
            target = target - CNT_W'(1);
         end
         if (target < CNT_W'(1)) begin
            target = CNT_W'(1);
         end
         if (target > CNT_W'(DIGIT_STORE_CHARS)) begin
            target = CNT_W'(DIGIT_STORE_CHARS);
         end
      end
   end

   // Classify the conversion
   always_comb begin
      job.valid_cmd = 1'b1;
      job.upper     = 1'b0;
      job.radix     = RADIX_DEC;
      case (cmd)
         CMD_SDEC: job.radix = RADIX_DEC;
         CMD_UDEC: job.radix = RADIX_DEC;
         CMD_OCT:  job.radix = RADIX_OCT;
         CMD_HEXL: job.radix = RADIX_HEX;
         CMD_HEXU: begin
            job.radix = RADIX_HEX;
            job.upper = 1'b1;
         end
         CMD_BIN:  job.radix = RADIX_BIN;
         default:  job.valid_cmd = 1'b0;
      endcase
      job.has_sign  = has_sign;
      job.sign_char = negative ? CHAR_MINUS : (plus_sign ? CHAR_PLUS : CHAR_SPACE);
      job.sep8      = (cmd == CMD_BIN) & alt_form;
      job.left      = left_align;
      job.min_width = minw_sat;
      job.target    = target;
   end

   // Magnitude of the number
   assign job_value = negative ? (~word + WORD_BITS'(1)) : word;

endmodule

// ===== sv/i2a_queue.sv =====
// Short job queue between the front end and the back end.
module i2a_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              not_empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push & ~full;
   assign do_pop    = pop & not_empty;
   assign pop_data  = slot_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/i2a_back.sv =====
// Back end: converts the magnitude to digits, stores them and emits the field.
module i2a_back import i2a_pkg::*; #(
   parameter int WORD_BITS         = 32,
   parameter int DIGIT_STORE_CHARS = 40,
   parameter int MAX_WIDTH         = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_valid,
   input  job_type                job,
   input  logic [WORD_BITS-1:0]   job_value,
   output logic                   job_pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // out_char[7:0]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast,
   // empty_res
   output logic [RSP_TUSER_W-1:0] rsp_tuser
);

   localparam int BCD_DIGITS  = (WORD_BITS * 30103) / 100000 + 1;
   localparam int BCD_W       = 4 * BCD_DIGITS;
   localparam int SR_W        = (BCD_W > WORD_BITS) ? BCD_W : WORD_BITS;
   localparam int DOT_CHARS   = (WORD_BITS - 1) / 8;
   localparam int STORE_DEPTH = (DIGIT_STORE_CHARS + 1 > WORD_BITS + DOT_CHARS) ?
                                DIGIT_STORE_CHARS + 1 : WORD_BITS + DOT_CHARS;
   localparam int AW          = $clog2(STORE_DEPTH);
   localparam int LW          = $clog2(STORE_DEPTH + 1);
   localparam int BW          = $clog2(WORD_BITS);
   localparam int KW          = $clog2(MAX_WIDTH + STORE_DEPTH + 2);

   back_state_type       state_ff, state_in;
   job_type              job_ff, job_in;
   logic [SR_W-1:0]      sr_ff, sr_in;
   logic [WORD_BITS-1:0] bin_ff, bin_in;
   logic [BW-1:0]        bit_cnt_ff, bit_cnt_in;
   logic [LW-1:0]        len_ff, len_in;
   logic [LW-1:0]        dcnt_ff, dcnt_in;
   logic                 dot_done_ff, dot_done_in;
   logic [KW-1:0]        k_ff, k_in;
   logic [KW-1:0]        total_ff, total_in;
   logic [KW-1:0]        pad_left_ff, pad_left_in;
   logic [KW-1:0]        body_end_ff, body_end_in;
   logic [AW-1:0]        rd_addr_ff, rd_addr_in;
   logic [7:0]           rd_data_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_char_ff, rsp_char_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_empty_ff, rsp_empty_in;
   logic [7:0]           store [STORE_DEPTH];

   logic                 wr_en;
   logic [7:0]           wr_char;
   logic                 rd_en;
   logic [BCD_W-1:0]     bcd_adj;
   logic [3:0]           digit;
   logic [7:0]           digit_chr;
   logic                 more;
   logic                 need_dot;
   logic                 out_free;
   logic                 out_last;
   logic [KW-1:0]        body;
   logic [KW-1:0]        minw_k;
   logic [KW-1:0]        span;
   logic [LW-1:0]        len_m1;

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_char_ff;
   assign rsp_tlast    = rsp_last_ff;
   assign rsp_tuser[0] = rsp_empty_ff;
   assign out_free     = ~rsp_valid_ff | rsp_tready;

   // Add three to every BCD digit of five or more before the shift
   always_comb begin
      logic [3:0] nib;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         nib = sr_ff[4*i +: 4];
         bcd_adj[4*i +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
      end
   end

   // Pick the low digit for the current radix and map it to a character
   always_comb begin
      case (job_ff.radix)
         RADIX_DEC: digit = sr_ff[3:0];
         RADIX_HEX: digit = sr_ff[3:0];
         RADIX_OCT: digit = {1'b0, sr_ff[2:0]};
         RADIX_BIN: digit = {3'b000, sr_ff[0]};
         default:   digit = sr_ff[3:0];
      endcase
      if (digit > 4'd9) begin
         digit_chr = (job_ff.upper ? CHAR_UPPER_A : CHAR_LOWER_A) + {4'b0000, digit} - 8'd10;
      end else begin
         digit_chr = CHAR_ZERO + {4'b0000, digit};
      end
   end

   assign more     = (sr_ff != '0) || (KW'(len_ff) < KW'(job_ff.target));
   assign need_dot = job_ff.sep8 && (dcnt_ff != '0) && (dcnt_ff[2:0] == 3'b000);
   assign body     = KW'(len_ff) + KW'(job_ff.has_sign);
   assign minw_k   = KW'(job_ff.min_width);
   assign span     = (body < minw_k) ? minw_k : body;
   assign len_m1   = len_ff - LW'(1);
   assign out_last = (k_ff + KW'(1) == total_ff);

   // Next state and datapath
   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      sr_in        = sr_ff;
      bin_in       = bin_ff;
      bit_cnt_in   = bit_cnt_ff;
      len_in       = len_ff;
      dcnt_in      = dcnt_ff;
      dot_done_in  = dot_done_ff;
      k_in         = k_ff;
      total_in     = total_ff;
      pad_left_in  = pad_left_ff;
      body_end_in  = body_end_ff;
      rd_addr_in   = rd_addr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_empty_in = rsp_empty_ff;
      job_pop      = 1'b0;
      wr_en        = 1'b0;
      wr_char      = digit_chr;
      rd_en        = 1'b0;

      // Drop the shown beat once taken
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop     = 1'b1;
               job_in      = job;
               len_in      = '0;
               dcnt_in     = '0;
               dot_done_in = 1'b0;
               bit_cnt_in  = '0;
               bin_in      = job_value;
               if (!job.valid_cmd) begin
                  state_in = ST_PREP;
               end else if (job.radix == RADIX_DEC) begin
                  sr_in    = '0;
                  state_in = ST_BCD;
               end else begin
                  sr_in    = SR_W'(job_value);
                  state_in = ST_GEN;
               end
            end
         end

         // Shift one binary bit into the BCD register per cycle
         ST_BCD: begin
            sr_in      = SR_W'({bcd_adj[BCD_W-2:0], bin_ff[WORD_BITS-1]});
            bin_in     = bin_ff << 1;
            bit_cnt_in = bit_cnt_ff + BW'(1);
            if (bit_cnt_ff == BW'(WORD_BITS - 1)) begin
               state_in = ST_GEN;
            end
         end

         // Write one character, least significant first
         ST_GEN: begin
            if (!dot_done_ff && !more) begin
               state_in = ST_PREP;
            end else if (need_dot && !dot_done_ff) begin
               wr_en       = 1'b1;
               wr_char     = CHAR_DOT;
               len_in      = len_ff + LW'(1);
               dot_done_in = 1'b1;
            end else begin
               wr_en       = 1'b1;
               len_in      = len_ff + LW'(1);
               dcnt_in     = dcnt_ff + LW'(1);
               dot_done_in = 1'b0;
               case (job_ff.radix)
                  RADIX_DEC: sr_in = sr_ff >> 4;
                  RADIX_HEX: sr_in = sr_ff >> 4;
                  RADIX_OCT: sr_in = sr_ff >> 3;
                  RADIX_BIN: sr_in = sr_ff >> 1;
                  default:   sr_in = sr_ff >> 4;
               endcase
            end
         end

         // Lay out the field and prefetch the leading digit
         ST_PREP: begin
            pad_left_in = (!job_ff.left && body < minw_k) ? minw_k - body : '0;
            body_end_in = ((!job_ff.left && body < minw_k) ? minw_k - body : '0) + body;
            if (!job_ff.valid_cmd) begin
               total_in = '0;
            end else begin
               total_in = (span > KW'(MAX_WIDTH)) ? KW'(MAX_WIDTH) : span;
            end
            k_in = '0;
            if (len_ff != '0) begin
               rd_en      = 1'b1;
               rd_addr_in = len_m1[AW-1:0];
            end
            state_in = ST_EMIT;
         end

         // Emit one character per free output slot
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_empty_in = 1'b0;
               if (total_ff == '0) begin
                  rsp_char_in  = CHAR_NUL;
                  rsp_last_in  = 1'b1;
                  rsp_empty_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  rsp_last_in = out_last;
                  if (k_ff < pad_left_ff) begin
                     rsp_char_in = CHAR_SPACE;
                  end else if (job_ff.has_sign && k_ff == pad_left_ff) begin
                     rsp_char_in = job_ff.sign_char;
                  end else if (k_ff < body_end_ff) begin
                     rsp_char_in = rd_data_ff;
                     if (rd_addr_ff != '0) begin
                        rd_en      = 1'b1;
                        rd_addr_in = rd_addr_ff - AW'(1);
                     end
                  end else begin
                     rsp_char_in = CHAR_SPACE;
                  end
                  k_in = k_ff + KW'(1);
                  if (out_last) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      job_ff       <= job_in;
      sr_ff        <= sr_in;
      bin_ff       <= bin_in;
      bit_cnt_ff   <= bit_cnt_in;
      len_ff       <= len_in;
      dcnt_ff      <= dcnt_in;
      dot_done_ff  <= dot_done_in;
      k_ff         <= k_in;
      total_ff     <= total_in;
      pad_left_ff  <= pad_left_in;
      body_end_ff  <= body_end_in;
      rd_addr_ff   <= rd_addr_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   // Digit store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[len_ff[AW-1:0]] <= wr_char;
      end
      if (rd_en) begin
         rd_data_ff <= store[rd_addr_in];
      end
   end

endmodule

// ===== sv/integer_to_ascii_formatter.sv =====
// Decimal kinds first pass through the shift-and-add-3 BCD converter; then every valid
// kind writes one digit store character per cycle (dots included), a layout step
// follows, and the field leaves at one character per cycle while the output is accepted.
// While an item occupies the back end, two more items can wait in the job queue.
// Synchronous active-high reset clears the state machine, the queue and the output beat;
// the digit store is not cleared.
module integer_to_ascii_formatter import i2a_pkg::*; #(
   parameter int WORD_BITS         = 32,
   parameter int DIGIT_STORE_CHARS = 40,
   parameter int MAX_WIDTH         = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // value[31:0], alt_form, zero_pad, space_sign, left_align, plus_sign,
   // min_width[6:0], has_precision, precision[5:0], zero fill
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // cmd[2:0]
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // out_char[7:0]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // last
   output logic                   rsp_tlast,
   // empty_res
   output logic [RSP_TUSER_W-1:0] rsp_tuser
);

   localparam int Q_W = $bits(job_type) + WORD_BITS;

   job_type              front_job;
   logic [WORD_BITS-1:0] front_value;
   logic                 front_push;
   logic                 queue_full;
   logic [Q_W-1:0]       queue_out;
   logic                 queue_valid;
   logic                 back_pop;
   job_type              back_job;
   logic [WORD_BITS-1:0] back_value;

   // Accept and classify
   i2a_front #(
      .WORD_BITS        (WORD_BITS),
      .DIGIT_STORE_CHARS(DIGIT_STORE_CHARS),
      .MAX_WIDTH        (MAX_WIDTH)
   ) u_front (
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .queue_full(queue_full),
      .job_push  (front_push),
      .job       (front_job),
      .job_value (front_value)
   );

   // Decouple front and back
   i2a_queue #(
      .DATA_W(Q_W),
      .DEPTH (2)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_push),
      .push_data({front_job, front_value}),
      .full     (queue_full),
      .pop      (back_pop),
      .pop_data (queue_out),
      .not_empty(queue_valid)
   );

   assign back_job   = queue_out[Q_W-1:WORD_BITS];
   assign back_value = queue_out[WORD_BITS-1:0];

   // Convert and emit
   i2a_back #(
      .WORD_BITS        (WORD_BITS),
      .DIGIT_STORE_CHARS(DIGIT_STORE_CHARS),
      .MAX_WIDTH        (MAX_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (queue_valid),
      .job       (back_job),
      .job_value (back_value),
      .job_pop   (back_pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser)
   );

endmodule
